// ----- hw/rtl/crank_nicolson_wave_step_top_defines.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef CRANK_NICOLSON_WAVE_STEP_TOP_DEFINES_SVH
`define CRANK_NICOLSON_WAVE_STEP_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define CNWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during rst.
`define CNWS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cnws_pkg.sv -----
`timescale 1ns / 1ps

package cnws_pkg;

  localparam int POINTS_DEF     = 64;
  localparam int VALUE_BITS_DEF = 32;

  localparam int POINT_W = 6;
  localparam int DISP_W  = 32;
  localparam int VEL_W   = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_ADDR_W-1:0] CFG_COURANT_SQUARED   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIME_STEP         = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERSE_TIME_STEP = 2'd2;

  localparam logic [CFG_DATA_W-1:0] COURANT_SQUARED_RST   = 31'd16777216;
  localparam logic [CFG_DATA_W-1:0] TIME_STEP_RST         = 31'd167772;
  localparam logic [CFG_DATA_W-1:0] INVERSE_TIME_STEP_RST = 31'd1677721600;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

// ----- hw/rtl/cnws_alu.sv -----
`timescale 1ns / 1ps

// Shared fixed-point unit: rounded multiply (four partial products) or
// rounded divide (restoring, one quotient bit a cycle), both saturating.
module cnws_alu #(
  parameter int VALUE_BITS = cnws_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cnws_pkg::alu_req_t req,
  input  logic signed [((VALUE_BITS > 32) ? VALUE_BITS : 32)-1:0] a,
  input  logic signed [((VALUE_BITS > 32) ? VALUE_BITS : 32)-1:0] b,
  output cnws_pkg::alu_sts_t sts,
  output logic signed [VALUE_BITS-1:0] res
);

  localparam int VB   = VALUE_BITS;
  localparam int FRAC = VB - 8;
  localparam int OPW  = (VB > 32) ? VB : 32;
  localparam int H    = (OPW + 1) / 2;
  localparam int PW   = 2 * OPW;
  localparam int NW   = OPW + FRAC;
  localparam int CW   = $clog2(NW + 1);

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_DIV  = 5'b00100,
    A_RND  = 5'b01000,
    A_FIN  = 5'b10000
  } alu_state_t;

  alu_state_t st;
  cnws_pkg::alu_op_t op_r;
  logic [OPW-1:0] ua, ub, a_mag, b_mag;
  logic           neg, dz, done_r;
  logic [CW-1:0]  cnt;
  logic [PW-1:0]  acc, fin, pp_sh;
  logic [NW-1:0]  dvd, quo;
  logic [OPW-1:0] rem;
  logic [OPW:0]   rem_sh;
  logic [H-1:0]   pa, pb;
  logic [2*H-1:0] pp;
  logic [PW-1:0]  lim, vmax;

  assign a_mag = a[OPW-1] ? (~a + 1'b1) : a;
  assign b_mag = b[OPW-1] ? (~b + 1'b1) : b;
  assign lim   = PW'(1) << (VB - 1);
  assign vmax  = lim - 1'b1;

  always_comb begin
    pa = cnt[0] ? H'(ua >> H) : ua[H-1:0];
    pb = cnt[1] ? H'(ub >> H) : ub[H-1:0];
    pp = pa * pb;
    case (cnt[1:0])
      2'd0:    pp_sh = PW'(pp);
      2'd1:    pp_sh = PW'(pp) << H;
      2'd2:    pp_sh = PW'(pp) << H;
      default: pp_sh = PW'(pp) << (2 * H);
    endcase
    rem_sh = {rem, dvd[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st)
        A_IDLE: begin
          if (req.start) begin
            ua   <= a_mag;
            ub   <= b_mag;
            op_r <= req.op;
            cnt  <= '0;
            acc  <= '0;
            rem  <= '0;
            quo  <= '0;
            dvd  <= {a_mag, FRAC'(0)};
            dz   <= (req.op == cnws_pkg::ALU_DIV) && (b == '0);
            if (req.op == cnws_pkg::ALU_DIV && b == '0) begin
              neg <= a[OPW-1];
              st  <= A_RND;
            end else begin
              neg <= a[OPW-1] ^ b[OPW-1];
              st  <= (req.op == cnws_pkg::ALU_MUL) ? A_MUL : A_DIV;
            end
          end
        end
        A_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 1'b1;
          if (cnt[1:0] == 2'd3) st <= A_RND;
        end
        A_DIV: begin
          if (rem_sh >= {1'b0, ub}) begin
            rem <= OPW'(rem_sh - {1'b0, ub});
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= OPW'(rem_sh);
            quo <= {quo[NW-2:0], 1'b0};
          end
          dvd <= dvd << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CW'(NW - 1)) st <= A_RND;
        end
        A_RND: begin
          if (op_r == cnws_pkg::ALU_MUL) begin
            fin <= (acc + (PW'(1) << (FRAC - 1))) >> FRAC;
          end else if (dz) begin
            fin <= (ua == '0) ? '0 : '1;
          end else begin
            fin <= PW'(quo) + PW'({rem, 1'b0} >= {1'b0, ub});
          end
          st <= A_FIN;
        end
        A_FIN: begin
          if (neg) begin
            res <= (fin >= lim) ? VB'(lim) : VB'(~fin + 1'b1);
          end else begin
            res <= (fin > vmax) ? VB'(vmax) : VB'(fin);
          end
          done_r <= 1'b1;
          st     <= A_IDLE;
        end
        default: st <= A_IDLE;
      endcase
    end
  end

  assign sts.busy = (st != A_IDLE);
  assign sts.done = done_r;

endmodule

// ----- hw/rtl/crank_nicolson_wave_step_top.sv -----
`timescale 1ns / 1ps
// Step words: a step word gives its first result only after the forward and back passes
// have run; a load word writes its point's displacement and gives no result. A new word
// is accepted only in idle, so a step word is not taken before the previous step is through;
// the work is set by the bit-serial divider (two divides a point) and the multiplies (up to six a point).
// Reset: rst synchronous, active high; clears control, config to defaults, velocity
// valid bits (velocity reads zero until written). No clearing pass.

module crank_nicolson_wave_step_top #(
  parameter int POINTS     = cnws_pkg::POINTS_DEF,
  parameter int VALUE_BITS = cnws_pkg::VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // slave words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [cnws_pkg::IN_DATA_W-1:0] s_tdata,   // point_index, displacement_in, pad
  input  logic [0:0]  s_tuser,                      // func
  // master words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [cnws_pkg::OUT_DATA_W-1:0] m_tdata,  // point_out, displacement_out,
                                                    // velocity_out, pad
  output logic        m_tlast,                      // last
  // configuration writes
  input  logic        cfg_wen,
  input  logic [cnws_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [cnws_pkg::CFG_DATA_W-1:0] cfg_wdata
);

`include "crank_nicolson_wave_step_top_defines.svh"

  localparam int VB   = VALUE_BITS;
  localparam int FRAC = VB - 8;
  localparam int OPW  = (VB > 32) ? VB : 32;
  localparam int AW   = OPW + 4;           // headroom for sums of a few terms
  localparam int IW   = $clog2(POINTS);

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_F_RD0 = 14'b00000000000010,
    ST_F_LD0 = 14'b00000000000100,
    ST_F_RDN = 14'b00000000001000,
    ST_F_LDN = 14'b00000000010000,
    ST_F_ALU = 14'b00000000100000,
    ST_F_WR  = 14'b00000001000000,
    ST_B_RD  = 14'b00000010000000,
    ST_B_LD  = 14'b00000100000000,
    ST_B_MUL = 14'b00001000000000,
    ST_U_RD  = 14'b00010000000000,
    ST_U_LD  = 14'b00100000000000,
    ST_U_MUL = 14'b01000000000000,
    ST_U_OUT = 14'b10000000000000
  } state_t;

  // micro-operations of one forward point
  typedef enum logic [2:0] {
    K_W_CUR  = 3'd0,   // rdiag * w[i]
    K_Q_CUR  = 3'd1,   // dt * q[i]
    K_EDGE   = 3'd2,   // first row: half * w[1]; else quarter * w[i-1]
    K_W_NEXT = 3'd3,   // quarter * w[i+1]
    K_PIVOT  = 3'd4,   // pivot = diag + quarter * factor[i-1]
    K_RHS    = 3'd5,   // rhs + quarter * y[i-1]
    K_FACTOR = 3'd6,   // factor[i] = -off / pivot
    K_SOLVE  = 3'd7    // y[i] = rhs / pivot
  } step_op_t;

  function automatic logic signed [VB-1:0] sat_acc(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi_l;
    logic signed [AW-1:0] lo_l;
    hi_l = (AW'(1) << (VB - 1)) - 1;
    lo_l = -hi_l - 1;
    if (v > hi_l) return VB'(hi_l);
    if (v < lo_l) return VB'(lo_l);
    return VB'(v);
  endfunction

  // configuration
  logic [cnws_pkg::CFG_DATA_W-1:0] cs, dts, invs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cs   <= cnws_pkg::COURANT_SQUARED_RST;
      dts  <= cnws_pkg::TIME_STEP_RST;
      invs <= cnws_pkg::INVERSE_TIME_STEP_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        cnws_pkg::CFG_COURANT_SQUARED:   cs   <= cfg_wdata;
        cnws_pkg::CFG_TIME_STEP:         dts  <= cfg_wdata;
        cnws_pkg::CFG_INVERSE_TIME_STEP: invs <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // matrix coefficients; the user must keep them static during a step, the block does not enforce it
  logic signed [OPW-1:0] half_op, quarter_op, nhalf_op, nquarter_op, dt_op, inv_op;
  logic signed [OPW-1:0] rdiag_op;
  logic signed [AW-1:0]  one_a;
  logic signed [VB-1:0]  diag_v, rdiag_v;

  assign half_op     = OPW'(cs >> 1);
  assign quarter_op  = OPW'(cs >> 2);
  assign nhalf_op    = -half_op;
  assign nquarter_op = -quarter_op;
  assign dt_op       = OPW'(dts);
  assign inv_op      = OPW'(invs);
  assign one_a       = AW'(1) << FRAC;
  assign diag_v      = sat_acc(one_a + AW'(half_op));
  assign rdiag_v     = sat_acc(one_a - AW'(half_op));
  assign rdiag_op    = OPW'(rdiag_v);

  // input word fields
  logic [cnws_pkg::POINT_W-1:0]       in_point;
  logic signed [cnws_pkg::DISP_W-1:0] in_disp;
  logic                               s_fire;

  assign in_point = s_tdata[cnws_pkg::POINT_W-1:0];
  assign in_disp  = s_tdata[cnws_pkg::POINT_W+cnws_pkg::DISP_W-1:cnws_pkg::POINT_W];
  assign s_fire   = s_tvalid && s_tready;

  // memory A: {w, q}; memory B: {factor, y/x}
  logic [2*VB-1:0] wq_mem  [POINTS];
  logic [2*VB-1:0] sfy_mem [POINTS];
  logic [POINTS-1:0] q_valid;
  logic [2*VB-1:0] a_rdata, b_rdata, a_wdata, b_wdata;
  logic            a_qv, a_re, a_we, b_re, b_we;
  logic [IW-1:0]   a_addr, b_addr;
  logic signed [VB-1:0] a_w, a_q, b_sf, b_y;

  always_ff @(posedge clk) begin
    if (a_we) wq_mem[a_addr] <= a_wdata;
    if (a_re) begin
      a_rdata <= wq_mem[a_addr];
      a_qv    <= q_valid[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) sfy_mem[b_addr] <= b_wdata;
    if (b_re) b_rdata <= sfy_mem[b_addr];
  end

  // velocity reads zero until its entry has been written
  always_ff @(posedge clk) begin
    if (rst) q_valid <= '0;
    else if (a_we) q_valid[a_addr] <= 1'b1;
  end

  assign a_w  = a_rdata[2*VB-1:VB];
  assign a_q  = a_qv ? a_rdata[VB-1:0] : '0;
  assign b_sf = b_rdata[2*VB-1:VB];
  assign b_y  = b_rdata[VB-1:0];

  // sequencer
  state_t   state;
  step_op_t k;
  logic     issued;
  logic [IW-1:0] idx;
  logic     last_pt, first_pt;
  logic signed [VB-1:0] w_prev, w_cur, w_next, q_cur, q_next;
  logic signed [VB-1:0] sf_prev, y_prev, sf_r, y_r, m_r, t_r, x_next, qn_r;
  logic signed [AW-1:0] acc;
  logic signed [VB-1:0] diff_v;
  logic signed [AW-1:0] sum_v;
  logic     out_free;

  cnws_pkg::alu_req_t alu_req;
  cnws_pkg::alu_sts_t alu_sts;
  logic signed [OPW-1:0] alu_a, alu_b;
  logic signed [VB-1:0]  alu_res;

  cnws_alu #(.VALUE_BITS(VALUE_BITS)) u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .a   (alu_a),
    .b   (alu_b),
    .sts (alu_sts),
    .res (alu_res)
  );

  assign last_pt  = (idx == IW'(POINTS - 1));
  assign first_pt = (idx == '0);
  assign diff_v   = sat_acc(AW'(b_y) - AW'(a_w));
  assign sum_v    = acc + AW'(alu_res);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  // operand and request select
  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = cnws_pkg::ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (state)
      ST_F_ALU: begin
        alu_req.start = !issued;
        case (k)
          K_W_CUR: begin
            alu_a = rdiag_op;
            alu_b = OPW'(w_cur);
          end
          K_Q_CUR: begin
            alu_a = dt_op;
            alu_b = OPW'(q_cur);
          end
          K_EDGE: begin
            alu_a = first_pt ? half_op : quarter_op;
            alu_b = first_pt ? OPW'(w_next) : OPW'(w_prev);
          end
          K_W_NEXT: begin
            alu_a = quarter_op;
            alu_b = OPW'(w_next);
          end
          K_PIVOT: begin
            alu_a = quarter_op;
            alu_b = OPW'(sf_prev);
          end
          K_RHS: begin
            alu_a = quarter_op;
            alu_b = OPW'(y_prev);
          end
          K_FACTOR: begin
            alu_req.op = cnws_pkg::ALU_DIV;
            alu_a      = first_pt ? nhalf_op : nquarter_op;
            alu_b      = OPW'(m_r);
          end
          K_SOLVE: begin
            alu_req.op = cnws_pkg::ALU_DIV;
            alu_a      = OPW'(t_r);
            alu_b      = OPW'(m_r);
          end
          default: ;
        endcase
      end
      ST_B_LD: begin
        alu_req.start = 1'b1;
        alu_a         = OPW'(b_sf);
        alu_b         = OPW'(x_next);
      end
      ST_U_LD: begin
        alu_req.start = 1'b1;
        alu_a         = OPW'(diff_v);
        alu_b         = inv_op;
      end
      default: ;
    endcase
  end

  // memory port select
  always_comb begin
    a_re    = 1'b0;
    a_we    = 1'b0;
    a_addr  = idx;
    a_wdata = {w_cur, qn_r};
    b_re    = 1'b0;
    b_we    = 1'b0;
    b_addr  = idx;
    b_wdata = {sf_r, y_r};
    case (state)
      ST_IDLE: begin
        a_addr  = in_point[IW-1:0];
        a_wdata = {sat_acc(AW'(in_disp)), VB'(0)};
        a_we    = s_fire && !s_tuser[0] &&
                  ((cnws_pkg::POINT_W + 1)'(in_point) < (cnws_pkg::POINT_W + 1)'(POINTS));
      end
      ST_F_RD0: begin
        a_addr = '0;
        a_re   = 1'b1;
      end
      ST_F_RDN: begin
        a_addr = idx + 1'b1;
        a_re   = !last_pt;
      end
      ST_F_WR: b_we = 1'b1;
      ST_B_RD: b_re = 1'b1;
      ST_B_MUL: begin
        b_wdata = {sf_r, sat_acc(AW'(y_r) - AW'(alu_res))};
        b_we    = alu_sts.done;
      end
      ST_U_RD: begin
        a_re = 1'b1;
        b_re = 1'b1;
      end
      ST_U_OUT: begin
        a_wdata = {y_r, qn_r};
        a_we    = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      k      <= K_W_CUR;
      issued <= 1'b0;
      idx    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire && s_tuser[0]) begin
            idx   <= '0;
            state <= ST_F_RD0;
          end
        end
        ST_F_RD0: state <= ST_F_LD0;
        ST_F_LD0: begin
          w_cur <= a_w;
          q_cur <= a_q;
          state <= ST_F_RDN;
        end
        ST_F_RDN: state <= ST_F_LDN;
        ST_F_LDN: begin
          // Dirichlet zero past the last point
          w_next <= last_pt ? '0 : a_w;
          q_next <= last_pt ? '0 : a_q;
          k      <= K_W_CUR;
          issued <= 1'b0;
          state  <= ST_F_ALU;
        end
        ST_F_ALU: begin
          if (alu_req.start) issued <= 1'b1;
          if (alu_sts.done) begin
            issued <= 1'b0;
            case (k)
              K_W_CUR: begin
                acc <= AW'(alu_res);
                k   <= K_Q_CUR;
              end
              K_Q_CUR: begin
                acc <= sum_v;
                k   <= K_EDGE;
              end
              K_EDGE: begin
                if (first_pt) begin
                  // Neumann row: pivot is the diagonal
                  t_r <= sat_acc(sum_v);
                  m_r <= diag_v;
                  k   <= K_FACTOR;
                end else begin
                  acc <= sum_v;
                  k   <= K_W_NEXT;
                end
              end
              K_W_NEXT: begin
                t_r <= sat_acc(sum_v);
                k   <= K_PIVOT;
              end
              K_PIVOT: begin
                m_r <= sat_acc(AW'(diag_v) + AW'(alu_res));
                k   <= K_RHS;
              end
              K_RHS: begin
                t_r <= sat_acc(AW'(t_r) + AW'(alu_res));
                if (last_pt) begin
                  sf_r <= '0;
                  k    <= K_SOLVE;
                end else begin
                  k <= K_FACTOR;
                end
              end
              K_FACTOR: begin
                sf_r <= alu_res;
                k    <= K_SOLVE;
              end
              K_SOLVE: begin
                y_r   <= alu_res;
                state <= ST_F_WR;
              end
              default: k <= K_W_CUR;
            endcase
          end
        end
        ST_F_WR: begin
          sf_prev <= sf_r;
          y_prev  <= y_r;
          w_prev  <= w_cur;
          w_cur   <= w_next;
          q_cur   <= q_next;
          if (last_pt) begin
            x_next <= y_r;
            idx    <= IW'(POINTS - 2);
            state  <= ST_B_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_F_RDN;
          end
        end
        ST_B_RD: state <= ST_B_LD;
        ST_B_LD: begin
          sf_r  <= b_sf;
          y_r   <= b_y;
          state <= ST_B_MUL;
        end
        ST_B_MUL: begin
          if (alu_sts.done) begin
            x_next <= sat_acc(AW'(y_r) - AW'(alu_res));
            if (first_pt) begin
              state <= ST_U_RD;
            end else begin
              idx   <= idx - 1'b1;
              state <= ST_B_RD;
            end
          end
        end
        ST_U_RD: state <= ST_U_LD;
        ST_U_LD: begin
          y_r   <= b_y;
          q_cur <= a_q;
          state <= ST_U_MUL;
        end
        ST_U_MUL: begin
          if (alu_sts.done) begin
            qn_r  <= sat_acc(AW'(alu_res) + AW'(alu_res) - AW'(q_cur));
            state <= ST_U_OUT;
          end
        end
        ST_U_OUT: begin
          if (out_free) begin
            if (last_pt) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_U_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register: holds one result word, so the sequencer stalls only while it is full and not taken
  logic [cnws_pkg::POINT_W-1:0] out_point;
  logic [cnws_pkg::DISP_W-1:0]  out_disp;
  logic [cnws_pkg::VEL_W-1:0]   out_vel;
  logic                         out_last;
  logic                         out_load;

  assign out_load = (state == ST_U_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_point <= cnws_pkg::POINT_W'(idx);
      out_disp  <= cnws_pkg::DISP_W'(y_r);
      out_vel   <= cnws_pkg::VEL_W'(qn_r);
      out_last  <= last_pt;
    end
  end

  assign m_tdata = {2'b00, out_vel, out_disp, out_point};
  assign m_tlast = out_last;

  `CNWS_ASSERT_NXT(a_step_enters_sweep, s_fire && s_tuser[0], state == ST_F_RD0, "step word did not start the forward pass")
  `CNWS_ASSERT_IMP(a_alu_start_idle, alu_req.start, !alu_sts.busy, "arithmetic unit started while busy")
  `CNWS_ASSERT_NXT(a_alu_done_pulse, alu_sts.done, !alu_sts.done, "arithmetic unit done held over two cycles")
  `CNWS_ASSERT_IMP(a_idle_alu_quiet, state == ST_IDLE, !alu_sts.busy, "arithmetic unit busy while sequencer idle")

endmodule
